// ===== design/sdh_pkg.sv =====
// Package with the shared types and constants of the stall detect homing block.
package sdh_pkg;

  localparam int unsigned CurW    = 15;
  localparam int unsigned SpdW    = 22;
  localparam int unsigned CurLimW = 14;
  localparam int unsigned SpdLimW = 21;
  localparam int unsigned TsW     = 32;
  localparam int unsigned AngW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MOVING = 2'd1,
    MODE_LOCKED = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CUR_LIMIT = 2'd0,
    REG_SPD_LIMIT = 2'd1,
    REG_DEBOUNCE  = 2'd2,
    REG_TARGET    = 2'd3
  } reg_idx_e;

  localparam logic [CurLimW-1:0]     CurLimitRst = 14'd2000;
  localparam logic [SpdLimW-1:0]     SpdLimitRst = 21'd480;
  localparam logic [TsW-1:0]         DebounceRst = 32'd100000;
  localparam logic signed [AngW-1:0] TargetRst   = -16'sd500;

endpackage

// ===== design/stall_detect_homing_fsm.sv =====
// Top level of the stall detect homing controller with its mode state machine.
//
//   Channel  Signals                                   Direction
//   in       in_valid_i / in_stall_o + tick fields     item in
//   out      out_valid_o / out_stall_i + result fields item out
//   cfg      cfg_we_i, cfg_idx_i, cfg_data_i           register write
//
// Each accepted item's result is written straight into the result register.
// One item is accepted per cycle; the only limit is the result register.
// Reset loads the register defaults and puts the machine in idle.
// A stall on the output side holds the result and stalls the input side
// only while the result register is full.
module stall_detect_homing_fsm #(
  parameter int unsigned TimeBits = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sdh_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sdh_pkg::CfgW-1:0]            cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [sdh_pkg::TsW-1:0]             timestamp_us_i,
  input  logic                                enable_req_i,
  input  logic signed [sdh_pkg::CurW-1:0]     motor_current_i,
  input  logic signed [sdh_pkg::SpdW-1:0]     motor_speed_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                drive_on_o,
  output logic signed [sdh_pkg::AngW-1:0]     drive_target_o,
  output logic [1:0]                          mode_o,
  output logic                                stall_pending_o
);

  localparam int unsigned CmpW = (TimeBits > sdh_pkg::TsW) ? TimeBits : sdh_pkg::TsW;

  logic [sdh_pkg::CurLimW-1:0]     cur_limit_q;
  logic [sdh_pkg::SpdLimW-1:0]     spd_limit_q;
  logic [sdh_pkg::TsW-1:0]         debounce_q;
  logic signed [sdh_pkg::AngW-1:0] target_q;

  sdh_pkg::mode_e      mode_q, mode_d;
  logic                timing_q, timing_d;
  logic [TimeBits-1:0] start_q, start_d;

  logic                            out_valid_q;
  logic                            drive_on_q, drive_on_d;
  logic signed [sdh_pkg::AngW-1:0] drive_target_q, drive_target_d;
  logic [1:0]                      mode_out_q;
  logic                            pending_q;

  logic                in_accept;
  logic                stalled;
  logic [CmpW-1:0]     ts_ext;
  logic [TimeBits-1:0] now;
  logic [TimeBits-1:0] elapsed;
  logic                expired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_limit_q <= sdh_pkg::CurLimitRst;
      spd_limit_q <= sdh_pkg::SpdLimitRst;
      debounce_q  <= sdh_pkg::DebounceRst;
      target_q    <= sdh_pkg::TargetRst;
    end else if (cfg_we_i) begin
      case (sdh_pkg::reg_idx_e'(cfg_idx_i))
        sdh_pkg::REG_CUR_LIMIT: cur_limit_q <= cfg_data_i[sdh_pkg::CurLimW-1:0];
        sdh_pkg::REG_SPD_LIMIT: spd_limit_q <= cfg_data_i[sdh_pkg::SpdLimW-1:0];
        sdh_pkg::REG_DEBOUNCE:  debounce_q  <= cfg_data_i[sdh_pkg::TsW-1:0];
        sdh_pkg::REG_TARGET:    target_q    <= cfg_data_i[sdh_pkg::AngW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  sdh_stall_det u_stall_det (
    .cur_i       (motor_current_i),
    .spd_i       (motor_speed_i),
    .cur_limit_i (cur_limit_q),
    .spd_limit_i (spd_limit_q),
    .stalled_o   (stalled)
  );

  assign ts_ext  = CmpW'(timestamp_us_i);
  assign now     = ts_ext[TimeBits-1:0];
  assign elapsed = now - start_q;
  assign expired = CmpW'(elapsed) >= CmpW'(debounce_q);

  always_comb begin
    mode_d   = mode_q;
    timing_d = timing_q;
    start_d  = start_q;
    case (mode_q)
      sdh_pkg::MODE_IDLE: begin
        timing_d = 1'b0;
        if (enable_req_i) begin
          mode_d = sdh_pkg::MODE_MOVING;
        end
      end
      sdh_pkg::MODE_MOVING: begin
        if (!enable_req_i) begin
          mode_d   = sdh_pkg::MODE_IDLE;
          timing_d = 1'b0;
        end else if (stalled) begin
          if (!timing_q) begin
            timing_d = 1'b1;
            start_d  = now;
          end else if (expired) begin
            mode_d   = sdh_pkg::MODE_LOCKED;
            timing_d = 1'b0;
          end
        end else begin
          timing_d = 1'b0;
        end
      end
      sdh_pkg::MODE_LOCKED: begin
        if (!enable_req_i) begin
          mode_d = sdh_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_d   = sdh_pkg::MODE_IDLE;
        timing_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    drive_on_d     = (mode_d == sdh_pkg::MODE_MOVING);
    drive_target_d = drive_on_d ? target_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sdh_pkg::MODE_IDLE;
      timing_q <= 1'b0;
      start_q  <= '0;
    end else if (in_accept) begin
      mode_q   <= mode_d;
      timing_q <= timing_d;
      start_q  <= start_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      drive_on_q     <= drive_on_d;
      drive_target_q <= drive_target_d;
      mode_out_q     <= mode_d;
      pending_q      <= timing_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_on_o      = drive_on_q;
  assign drive_target_o  = drive_target_q;
  assign mode_o          = mode_out_q;
  assign stall_pending_o = pending_q;

  a_timing_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    timing_q |-> (mode_q == sdh_pkg::MODE_MOVING))
    else $error("Stall timer runs outside the moving mode.");

  a_drop_enable_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !enable_req_i) |=> (mode_q == sdh_pkg::MODE_IDLE))
    else $error("Dropping enable did not return to idle.");

  a_drive_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_on_q == (mode_out_q == sdh_pkg::MODE_MOVING)))
    else $error("Drive flag disagrees with the reported mode.");

  a_empty_never_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("Input stalled while the result register is empty.");

  a_result_state_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (mode_out_q == mode_q) && (pending_q == timing_q))
    else $error("Result register disagrees with the state after the item.");

endmodule

// ===== design/sdh_stall_det.sv =====
// Stall condition check: high absolute current with low absolute speed.
module sdh_stall_det (
  input  logic signed [sdh_pkg::CurW-1:0]    cur_i,
  input  logic signed [sdh_pkg::SpdW-1:0]    spd_i,
  input  logic        [sdh_pkg::CurLimW-1:0] cur_limit_i,
  input  logic        [sdh_pkg::SpdLimW-1:0] spd_limit_i,
  output logic                               stalled_o
);

  logic [sdh_pkg::CurW-1:0] cur_abs;
  logic [sdh_pkg::SpdW-1:0] spd_abs;

  assign cur_abs = cur_i[sdh_pkg::CurW-1] ? sdh_pkg::CurW'(-cur_i) : sdh_pkg::CurW'(cur_i);
  assign spd_abs = spd_i[sdh_pkg::SpdW-1] ? sdh_pkg::SpdW'(-spd_i) : sdh_pkg::SpdW'(spd_i);

  assign stalled_o = (cur_abs > sdh_pkg::CurW'(cur_limit_i)) &&
                     (spd_abs < sdh_pkg::SpdW'(spd_limit_i));

endmodule
